// File: sv/etofa_pkg.sv
// Shared constants, types and codes of the echo time-of-flight averager.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package etofa_pkg;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int LEVEL_W     = SAMPLE_W + 1;
    localparam int PERIOD_W    = 8;
    localparam int SUM_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int CPR_W       = 5;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;

    // Averaging sequence length
    localparam int MAX_CAPTURES = 16;
    localparam int CNT_W        = $clog2(MAX_CAPTURES + 1);

    // Divider sizing: dividend holds the saturated sum plus half the count
    localparam int DIVD_W = $clog2(2 ** SUM_W + MAX_CAPTURES / 2);
    localparam int DCNT_W = $clog2(DIVD_W + 1);

    // Capture queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] ECHO_THRESHOLD_RST = 12'd2048;
    localparam logic [SAMPLE_W-1:0] HYSTERESIS_RST     = 12'd0;
    localparam logic [PERIOD_W-1:0] MIN_DISTANCE_RST   = 8'd0;
    localparam logic [CPR_W-1:0]    CAPTURES_RST       = 5'd8;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ECHO_THRESHOLD = 2'd0,
        REG_HYSTERESIS     = 2'd1,
        REG_MIN_DISTANCE   = 2'd2,
        REG_CAPTURES       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] echo_threshold;
        logic [SAMPLE_W-1:0] hysteresis_margin;
        logic [PERIOD_W-1:0] min_distance_periods;
        logic [CPR_W-1:0]    captures_per_result;
    } cfg_t;

    // One finished capture as handed from front to back
    typedef struct packed {
        logic                echo_seen;
        logic [PERIOD_W-1:0] echo_index;
    } capture_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_OUTPUT
    } back_state_t;

endpackage

`default_nettype wire

// File: sv/etofa_ifs.sv
// Handshake interfaces of the averager: sample stream, result stream and
// configuration writes. Depends on etofa_pkg for the field widths.
`default_nettype none

interface etofa_sample_if
    import etofa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface etofa_result_if
    import etofa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                echo_found;
    logic [PERIOD_W-1:0] echo_period;
    logic                sequence_done;
    logic [PERIOD_W-1:0] average_period;

    modport source (output valid, output echo_found, output echo_period,
                    output sequence_done, output average_period, input ready);
    modport sink   (input valid, input echo_found, input echo_period,
                    input sequence_done, input average_period, output ready);
endinterface

interface etofa_cfg_if
    import etofa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/echo_time_of_flight_averager.sv
// Top level of the echo time-of-flight averager: configuration registers,
// front end, capture queue and back end. Depends on etofa_pkg and etofa_ifs.
//
// Samples are taken one per clock cycle while the capture queue has room.
// Each capture produces one result item on its last sample; the back end
// takes the record, shows the result and waits for it to be taken, and on a
// capture that completes a sequence with an echo in every capture it first
// runs the restoring divider over the DIVD_W (13) dividend bits. A four-entry
// capture queue lets the front end keep sampling during that time, so only
// captures of very few samples stall the sample channel. Configuration
// writes are always accepted.
`default_nettype none

module echo_time_of_flight_averager
    import etofa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    etofa_sample_if.sink   samples,
    etofa_result_if.source results,
    etofa_cfg_if.sink      cfg
);

    cfg_t     cfg_reg, cfg_next;
    capture_t push_data;
    logic     push_valid;
    logic     push_ready;
    capture_t pop_data;
    logic     pop_valid;
    logic     pop_ready;

    // Register writes.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_ECHO_THRESHOLD: cfg_next.echo_threshold       = cfg.data[SAMPLE_W-1:0];
                REG_HYSTERESIS:     cfg_next.hysteresis_margin    = cfg.data[SAMPLE_W-1:0];
                REG_MIN_DISTANCE:   cfg_next.min_distance_periods = cfg.data[PERIOD_W-1:0];
                REG_CAPTURES:       cfg_next.captures_per_result  = cfg.data[CPR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.echo_threshold       <= ECHO_THRESHOLD_RST;
            cfg_reg.hysteresis_margin    <= HYSTERESIS_RST;
            cfg_reg.min_distance_periods <= MIN_DISTANCE_RST;
            cfg_reg.captures_per_result  <= CAPTURES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    etofa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    etofa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    etofa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_data  (pop_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .results   (results)
    );

endmodule

`default_nettype wire

// File: sv/etofa_front.sv
// Front end: takes samples, finds the first threshold crossing of each
// capture and pushes one capture record per capture. Depends on etofa_pkg.
`default_nettype none

module etofa_front
    import etofa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    etofa_sample_if.sink samples,
    output capture_t     push_data,
    output logic         push_valid,
    input  wire logic    push_ready
);

    logic [PERIOD_W-1:0] sample_index_reg, sample_index_next;
    logic                echo_seen_reg, echo_seen_next;
    logic [PERIOD_W-1:0] echo_index_reg, echo_index_next;
    logic [LEVEL_W-1:0]  level;
    logic                crossing;
    logic                seen_now;
    logic [PERIOD_W-1:0] index_now;
    logic                accept;

    // A sample is taken whenever the queue has room for a possible record.
    assign samples.ready = push_ready;
    assign accept        = samples.valid && push_ready;

    // Crossing test against threshold plus margin, one bit wider to avoid wrap.
    assign level    = {1'b0, cfg.echo_threshold} + {1'b0, cfg.hysteresis_margin};
    assign crossing = {1'b0, samples.sample} > level;

    assign seen_now  = echo_seen_reg || crossing;
    assign index_now = echo_seen_reg ? echo_index_reg : sample_index_reg;

    assign push_valid           = accept && samples.last_sample;
    assign push_data.echo_seen  = seen_now;
    assign push_data.echo_index = index_now;

    // Capture tracking; the last sample clears it for the next capture.
    always_comb
    begin
        sample_index_next = sample_index_reg;
        echo_seen_next    = echo_seen_reg;
        echo_index_next   = echo_index_reg;
        if (accept)
        begin
            if (samples.last_sample)
            begin
                sample_index_next = '0;
                echo_seen_next    = 1'b0;
                echo_index_next   = '0;
            end
            else
            begin
                echo_seen_next  = seen_now;
                echo_index_next = index_now;
                if (sample_index_reg != PERIOD_MAX)
                begin
                    sample_index_next = sample_index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            echo_seen_reg    <= 1'b0;
            echo_index_reg   <= '0;
        end
        else
        begin
            sample_index_reg <= sample_index_next;
            echo_seen_reg    <= echo_seen_next;
            echo_index_reg   <= echo_index_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/etofa_queue.sv
// Short queue of capture records between front and back end.
// Depends on etofa_pkg for the record type and depth.
`default_nettype none

module etofa_queue
    import etofa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire capture_t push_data,
    input  wire logic     push_valid,
    output logic          push_ready,
    output capture_t      pop_data,
    output logic          pop_valid,
    input  wire logic     pop_ready
);

    capture_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("capture queue fill count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("capture queue lost a record on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("capture queue pointers disagree with fill count");

endmodule

`default_nettype wire

// File: sv/etofa_divider.sv
// Restoring divider, one quotient bit per cycle, for the sequence average.
// Depends on etofa_pkg for the request and response types.
`default_nettype none

module etofa_divider
    import etofa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [CNT_W:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic [DCNT_W-1:0] steps_reg, steps_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    rem_shift;
    logic              fits;

    // One step: shift the next dividend bit into the remainder and try a subtract.
    assign rem_shift = {rem_reg[CNT_W-1:0], quot_reg[DIVD_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        steps_next   = steps_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            rem_next     = '0;
            quot_next    = req.dividend;
            divisor_next = req.divisor;
            steps_next   = DCNT_W'(DIVD_W);
        end
        else if (steps_reg != '0)
        begin
            rem_next   = fits ? rem_shift - {1'b0, divisor_reg} : rem_shift;
            quot_next  = {quot_reg[DIVD_W-2:0], fits};
            steps_next = steps_reg - 1'b1;
            done_next  = steps_reg == DCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

// File: sv/etofa_back.sv
// Back end: turns capture records into echo periods, keeps the sequence sum
// and counts, and drives the result channel. Depends on etofa_pkg and etofa_divider.
`default_nettype none

module etofa_back
    import etofa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire capture_t  pop_data,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    etofa_result_if.source results
);

    back_state_t         state_reg, state_next;
    logic [SUM_W-1:0]    period_sum_reg, period_sum_next;
    logic [CNT_W-1:0]    valid_captures_reg, valid_captures_next;
    logic [CNT_W-1:0]    captures_done_reg, captures_done_next;
    logic                found_reg, found_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                seq_done_reg, seq_done_next;
    logic [PERIOD_W-1:0] avg_reg, avg_next;

    logic [PERIOD_W:0]   period_wide;
    logic [PERIOD_W-1:0] period;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [CNT_W-1:0]    valid_new;
    logic [CNT_W-1:0]    n;
    logic [CNT_W-1:0]    eff_count;
    logic                seq_end;
    logic                div_start;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    etofa_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Count in force, held to the range one to the maximum.
    always_comb
    begin
        priority if (cfg.captures_per_result == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (int'(cfg.captures_per_result) > MAX_CAPTURES)
        begin
            eff_count = CNT_W'(MAX_CAPTURES);
        end
        else
        begin
            eff_count = CNT_W'(cfg.captures_per_result);
        end
    end

    // Period of the popped capture and the updated sequence totals.
    assign period_wide = {1'b0, pop_data.echo_index} + (PERIOD_W + 1)'(1)
                         + {1'b0, cfg.min_distance_periods};
    assign period   = !pop_data.echo_seen ? '0 :
                      period_wide[PERIOD_W] ? PERIOD_MAX : period_wide[PERIOD_W-1:0];
    assign sum_wide = {1'b0, period_sum_reg} + (SUM_W + 1)'(period);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign valid_new = valid_captures_reg + CNT_W'(pop_data.echo_seen);
    assign n         = captures_done_reg + CNT_W'(1);
    assign seq_end   = n >= eff_count;

    assign div_req = '{start:    div_start,
                       dividend: DIVD_W'(sum_sat) + DIVD_W'(n >> 1),
                       divisor:  n};

    // Sequencer: take a record, divide at an all-echo sequence end, hold the result.
    always_comb
    begin
        state_next          = state_reg;
        period_sum_next     = period_sum_reg;
        valid_captures_next = valid_captures_reg;
        captures_done_next  = captures_done_reg;
        found_next          = found_reg;
        period_next         = period_reg;
        seq_done_next       = seq_done_reg;
        avg_next            = avg_reg;
        pop_ready           = 1'b0;
        div_start           = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    found_next    = pop_data.echo_seen;
                    period_next   = period;
                    seq_done_next = seq_end;
                    avg_next      = '0;
                    state_next    = BK_OUTPUT;
                    if (seq_end)
                    begin
                        period_sum_next     = '0;
                        valid_captures_next = '0;
                        captures_done_next  = '0;
                        if (valid_new == n)
                        begin
                            div_start  = 1'b1;
                            state_next = BK_DIVIDE;
                        end
                    end
                    else
                    begin
                        period_sum_next     = sum_sat;
                        valid_captures_next = valid_new;
                        captures_done_next  = n;
                    end
                end
            end
            BK_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = (div_rsp.quotient > DIVD_W'(PERIOD_MAX)) ? PERIOD_MAX
                                 : div_rsp.quotient[PERIOD_W-1:0];
                    state_next = BK_OUTPUT;
                end
            end
            BK_OUTPUT:
            begin
                if (results.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= BK_IDLE;
            period_sum_reg     <= '0;
            valid_captures_reg <= '0;
            captures_done_reg  <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            period_sum_reg     <= period_sum_next;
            valid_captures_reg <= valid_captures_next;
            captures_done_reg  <= captures_done_next;
        end
    end

    // Result payload holds while it waits.
    always_ff @(posedge clk)
    begin
        found_reg    <= found_next;
        period_reg   <= period_next;
        seq_done_reg <= seq_done_next;
        avg_reg      <= avg_next;
    end

    assign results.valid          = state_reg == BK_OUTPUT;
    assign results.echo_found     = found_reg;
    assign results.echo_period    = period_reg;
    assign results.sequence_done  = seq_done_reg;
    assign results.average_period = avg_reg;

    a_div_only_when_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == BK_DIVIDE)
        else $error("divider finished outside the divide state");

    a_avg_needs_seq_end: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.average_period != '0) |-> results.sequence_done)
        else $error("average given on a capture that does not end a sequence");

    a_period_needs_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.echo_found) |-> results.echo_period == '0)
        else $error("echo period given for a capture without an echo");

    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_captures_reg <= captures_done_reg)
        else $error("more captures with an echo than captures taken");

endmodule

`default_nettype wire
